// File: rtl/core/sdf_pkg.sv
// shared widths, register indexes and reset values for the spring damper force block
`default_nettype none
package sdf_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DIFF_W = 33;
   localparam int unsigned COEF_W = 31;
   localparam int unsigned RAD_W  = 68;
   localparam int unsigned ROOT_W = 34;
   localparam int unsigned QUO_W  = 31;
   localparam int unsigned IDX_W  = 8;

   localparam logic [IDX_W-1:0] CSR_REST_LENGTH   = 8'd0;
   localparam logic [IDX_W-1:0] CSR_STIFFNESS     = 8'd1;
   localparam logic [IDX_W-1:0] CSR_DAMPING_COEFF = 8'd2;

   localparam logic [COEF_W-1:0] REST_LENGTH_RESET   = 31'd13107200;
   localparam logic [COEF_W-1:0] STIFFNESS_RESET     = 31'd1966080;
   localparam logic [COEF_W-1:0] DAMPING_COEFF_RESET = 31'd1310720;

endpackage
`default_nettype wire

// File: rtl/core/spring_damper_force.sv
// top level of the damped two-point spring force pipeline
//
// Fully pipelined: one request is taken every clock cycle and busy never rises.
// Each request gives exactly one result on rsp_valid; between the two lie the 34-stage
// square root and the 31-stage divider, one bit per stage, plus thirteen stages of
// differences, multiplies and saturation. The result strobe cannot be held off.
// Registers are written through the csr port, which is always ready; write them
// only while no request is in flight.
`default_nettype none
module spring_damper_force (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_anchor_a_x,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_anchor_a_y,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_anchor_b_x,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_anchor_b_y,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_vel_a_x,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_vel_a_y,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_vel_b_x,
   input  wire logic signed [sdf_pkg::DATA_W-1:0] req_vel_b_y,
   output logic                                   rsp_valid,
   output logic signed [sdf_pkg::DATA_W-1:0]      rsp_force_x,
   output logic signed [sdf_pkg::DATA_W-1:0]      rsp_force_y,
   output logic                                   rsp_saturated,
   output logic                                   rsp_coincident,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sdf_pkg::IDX_W-1:0]         csr_index,
   input  wire logic [sdf_pkg::DATA_W-1:0]        csr_data
);

   localparam int unsigned DW   = sdf_pkg::DIFF_W;
   localparam int unsigned CW   = sdf_pkg::COEF_W;
   localparam int unsigned LW   = sdf_pkg::ROOT_W;
   localparam int unsigned QW   = sdf_pkg::QUO_W;
   localparam int unsigned SQ_SIDE_W  = 4 * DW + 5;
   localparam int unsigned DIV_SIDE_W = 2 * DW + 5;

   // configuration registers
   logic [CW-1:0] rest_ff, stiff_ff, damp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= sdf_pkg::REST_LENGTH_RESET;
         stiff_ff <= sdf_pkg::STIFFNESS_RESET;
         damp_ff  <= sdf_pkg::DAMPING_COEFF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sdf_pkg::CSR_REST_LENGTH:   rest_ff  <= csr_data[CW-1:0];
            sdf_pkg::CSR_STIFFNESS:     stiff_ff <= csr_data[CW-1:0];
            sdf_pkg::CSR_DAMPING_COEFF: damp_ff  <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // stage a: differences
   logic                 a_v_ff;
   logic signed [DW-1:0] a_dx_ff, a_dy_ff, a_dvx_ff, a_dvy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start;
      end
      a_dx_ff  <= {req_anchor_a_x[31], req_anchor_a_x} - {req_anchor_b_x[31], req_anchor_b_x};
      a_dy_ff  <= {req_anchor_a_y[31], req_anchor_a_y} - {req_anchor_b_y[31], req_anchor_b_y};
      a_dvx_ff <= {req_vel_a_x[31], req_vel_a_x} - {req_vel_b_x[31], req_vel_b_x};
      a_dvy_ff <= {req_vel_a_y[31], req_vel_a_y} - {req_vel_b_y[31], req_vel_b_y};
   end

   // stage b: magnitudes and signs
   logic          b_v_ff, b_coin_ff;
   logic [DW-1:0] b_adx_ff, b_ady_ff, b_advx_ff, b_advy_ff;
   logic          b_sdx_ff, b_sdy_ff, b_sdvx_ff, b_sdvy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
      b_adx_ff  <= a_dx_ff[DW-1]  ? DW'(-a_dx_ff)  : DW'(a_dx_ff);
      b_ady_ff  <= a_dy_ff[DW-1]  ? DW'(-a_dy_ff)  : DW'(a_dy_ff);
      b_advx_ff <= a_dvx_ff[DW-1] ? DW'(-a_dvx_ff) : DW'(a_dvx_ff);
      b_advy_ff <= a_dvy_ff[DW-1] ? DW'(-a_dvy_ff) : DW'(a_dvy_ff);
      b_sdx_ff  <= a_dx_ff[DW-1];
      b_sdy_ff  <= a_dy_ff[DW-1];
      b_sdvx_ff <= a_dvx_ff[DW-1];
      b_sdvy_ff <= a_dvy_ff[DW-1];
      b_coin_ff <= (a_dx_ff == '0) && (a_dy_ff == '0);
   end

   // stage c: squares
   logic                   c_v_ff;
   logic [2*DW-1:0]        c_sqx_ff, c_sqy_ff;
   logic [SQ_SIDE_W-1:0]   c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= b_v_ff;
      end
      c_sqx_ff  <= b_adx_ff * b_adx_ff;
      c_sqy_ff  <= b_ady_ff * b_ady_ff;
      c_side_ff <= {b_adx_ff, b_ady_ff, b_sdx_ff, b_sdy_ff, b_advx_ff, b_advy_ff,
                    b_sdvx_ff, b_sdvy_ff, b_coin_ff};
   end

   // stage d: sum of squares
   logic                        d_v_ff;
   logic [sdf_pkg::RAD_W-1:0]   d_rad_ff;
   logic [SQ_SIDE_W-1:0]        d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else begin
         d_v_ff <= c_v_ff;
      end
      d_rad_ff  <= {2'b00, c_sqx_ff} + {2'b00, c_sqy_ff};
      d_side_ff <= c_side_ff;
   end

   // square root
   logic                 sq_v;
   logic [LW-1:0]        sq_len;
   logic [SQ_SIDE_W-1:0] sq_side;

   sdf_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_v_ff),
      .in_rad    (d_rad_ff),
      .in_side   (d_side_ff),
      .out_valid (sq_v),
      .out_root  (sq_len),
      .out_side  (sq_side)
   );

   logic [DW-1:0] sq_adx, sq_ady;
   logic [DIV_SIDE_W-1:0] sq_rest;

   assign {sq_adx, sq_ady, sq_rest} = sq_side;

   // unit vector
   logic                  dv_v;
   logic [QW-1:0]         dv_qx, dv_qy;
   logic [LW-1:0]         dv_len;
   logic [DIV_SIDE_W-1:0] dv_side;

   sdf_div #(.SIDE_W(DIV_SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_v),
      .in_num_x  (sq_adx),
      .in_num_y  (sq_ady),
      .in_den    (sq_len),
      .in_side   (sq_rest),
      .out_valid (dv_v),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_den   (dv_len),
      .out_side  (dv_side)
   );

   logic          dv_sdx, dv_sdy, dv_sdvx, dv_sdvy, dv_coin;
   logic [DW-1:0] dv_advx, dv_advy;

   assign {dv_sdx, dv_sdy, dv_advx, dv_advy, dv_sdvx, dv_sdvy, dv_coin} = dv_side;

   // stage e: velocity projections, stretch
   logic                   e_v_ff, e_svx_ff, e_svy_ff, e_sdx_ff, e_sdy_ff, e_coin_ff;
   logic [DW+QW-1:0]       e_pvx_ff, e_pvy_ff;
   logic signed [LW:0]     e_dl_ff;
   logic [QW-1:0]          e_qx_ff, e_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else begin
         e_v_ff <= dv_v;
      end
      e_pvx_ff  <= dv_advx * dv_qx;
      e_pvy_ff  <= dv_advy * dv_qy;
      e_svx_ff  <= dv_sdvx ^ dv_sdx;
      e_svy_ff  <= dv_sdvy ^ dv_sdy;
      e_dl_ff   <= {1'b0, dv_len} - (LW+1)'(rest_ff);
      e_sdx_ff  <= dv_sdx;
      e_sdy_ff  <= dv_sdy;
      e_coin_ff <= dv_coin;
      e_qx_ff   <= dv_qx;
      e_qy_ff   <= dv_qy;
   end

   // stage f: relative speed, spring product
   localparam int unsigned PV_W  = DW + QW - 30;
   localparam int unsigned REL_W = PV_W + 2;
   localparam int unsigned PK_W  = CW + LW + 1;

   logic [REL_W-1:0] f_tx, f_ty;
   logic [LW:0]      f_adl;

   always_comb begin
      f_tx  = e_svx_ff ? REL_W'(-{2'b00, e_pvx_ff[DW+QW-1:30]}) : {2'b00, e_pvx_ff[DW+QW-1:30]};
      f_ty  = e_svy_ff ? REL_W'(-{2'b00, e_pvy_ff[DW+QW-1:30]}) : {2'b00, e_pvy_ff[DW+QW-1:30]};
      f_adl = e_dl_ff[LW] ? (LW+1)'(-e_dl_ff) : (LW+1)'(e_dl_ff);
   end

   logic                     f_v_ff, f_sk_ff, f_sdx_ff, f_sdy_ff, f_coin_ff;
   logic signed [REL_W-1:0]  f_rel_ff;
   logic [PK_W-1:0]          f_pk_ff;
   logic [QW-1:0]            f_qx_ff, f_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= e_v_ff;
      end
      f_rel_ff  <= f_tx + f_ty;
      f_pk_ff   <= stiff_ff * f_adl;
      f_sk_ff   <= e_dl_ff[LW];
      f_sdx_ff  <= e_sdx_ff;
      f_sdy_ff  <= e_sdy_ff;
      f_coin_ff <= e_coin_ff;
      f_qx_ff   <= e_qx_ff;
      f_qy_ff   <= e_qy_ff;
   end

   // stage g: spring term, speed magnitude
   localparam int unsigned KT_W = PK_W - 16 + 2;

   logic                     g_v_ff, g_srel_ff, g_sdx_ff, g_sdy_ff, g_coin_ff;
   logic [REL_W-1:0]         g_arel_ff;
   logic signed [KT_W-1:0]   g_kt_ff;
   logic [QW-1:0]            g_qx_ff, g_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else begin
         g_v_ff <= f_v_ff;
      end
      g_arel_ff <= f_rel_ff[REL_W-1] ? REL_W'(-f_rel_ff) : REL_W'(f_rel_ff);
      g_srel_ff <= f_rel_ff[REL_W-1];
      g_kt_ff   <= f_sk_ff ? KT_W'(-{2'b00, f_pk_ff[PK_W-1:16]}) : {2'b00, f_pk_ff[PK_W-1:16]};
      g_sdx_ff  <= f_sdx_ff;
      g_sdy_ff  <= f_sdy_ff;
      g_coin_ff <= f_coin_ff;
      g_qx_ff   <= f_qx_ff;
      g_qy_ff   <= f_qy_ff;
   end

   // stage h: damping product
   localparam int unsigned PD_W = CW + REL_W;

   logic                     h_v_ff, h_srel_ff, h_sdx_ff, h_sdy_ff, h_coin_ff;
   logic [PD_W-1:0]          h_pd_ff;
   logic signed [KT_W-1:0]   h_kt_ff;
   logic [QW-1:0]            h_qx_ff, h_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else begin
         h_v_ff <= g_v_ff;
      end
      h_pd_ff   <= damp_ff * g_arel_ff;
      h_srel_ff <= g_srel_ff;
      h_kt_ff   <= g_kt_ff;
      h_sdx_ff  <= g_sdx_ff;
      h_sdy_ff  <= g_sdy_ff;
      h_coin_ff <= g_coin_ff;
      h_qx_ff   <= g_qx_ff;
      h_qy_ff   <= g_qy_ff;
   end

   // stage i: force magnitude along the axis
   localparam int unsigned M_W = PD_W - 16 + 2;

   logic [M_W-1:0] i_dt;

   always_comb begin
      i_dt = h_srel_ff ? M_W'(-{2'b00, h_pd_ff[PD_W-1:16]}) : {2'b00, h_pd_ff[PD_W-1:16]};
   end

   logic                    i_v_ff, i_sdx_ff, i_sdy_ff, i_coin_ff;
   logic signed [M_W-1:0]   i_m_ff;
   logic [QW-1:0]           i_qx_ff, i_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else begin
         i_v_ff <= h_v_ff;
      end
      i_m_ff    <= M_W'(h_kt_ff) + i_dt;
      i_sdx_ff  <= h_sdx_ff;
      i_sdy_ff  <= h_sdy_ff;
      i_coin_ff <= h_coin_ff;
      i_qx_ff   <= h_qx_ff;
      i_qy_ff   <= h_qy_ff;
   end

   // stage j: magnitude and signs of the components
   logic            j_v_ff, j_sfx_ff, j_sfy_ff, j_coin_ff;
   logic [M_W-1:0]  j_am_ff;
   logic [QW-1:0]   j_qx_ff, j_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_v_ff <= 1'b0;
      end else begin
         j_v_ff <= i_v_ff;
      end
      j_am_ff   <= i_m_ff[M_W-1] ? M_W'(-i_m_ff) : M_W'(i_m_ff);
      j_sfx_ff  <= i_m_ff[M_W-1] ^ i_sdx_ff;
      j_sfy_ff  <= i_m_ff[M_W-1] ^ i_sdy_ff;
      j_coin_ff <= i_coin_ff;
      j_qx_ff   <= i_qx_ff;
      j_qy_ff   <= i_qy_ff;
   end

   // stage k: split partial products
   localparam int unsigned LO_W = 26;
   localparam int unsigned HI_W = M_W - LO_W;

   logic                    k_v_ff, k_sfx_ff, k_sfy_ff, k_coin_ff;
   logic [LO_W+QW-1:0]      k_pxl_ff, k_pyl_ff;
   logic [HI_W+QW-1:0]      k_pxh_ff, k_pyh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else begin
         k_v_ff <= j_v_ff;
      end
      k_pxl_ff  <= j_am_ff[LO_W-1:0] * j_qx_ff;
      k_pyl_ff  <= j_am_ff[LO_W-1:0] * j_qy_ff;
      k_pxh_ff  <= j_am_ff[M_W-1:LO_W] * j_qx_ff;
      k_pyh_ff  <= j_am_ff[M_W-1:LO_W] * j_qy_ff;
      k_sfx_ff  <= j_sfx_ff;
      k_sfy_ff  <= j_sfy_ff;
      k_coin_ff <= j_coin_ff;
   end

   // stage l: combine and scale
   localparam int unsigned SUM_W = M_W + QW;
   localparam int unsigned FM_W  = SUM_W - 30;

   logic [SUM_W-1:0] l_sx, l_sy;

   always_comb begin
      l_sx = {k_pxh_ff, {LO_W{1'b0}}} + SUM_W'(k_pxl_ff);
      l_sy = {k_pyh_ff, {LO_W{1'b0}}} + SUM_W'(k_pyl_ff);
   end

   logic             l_v_ff, l_sfx_ff, l_sfy_ff, l_coin_ff;
   logic [FM_W-1:0]  l_fmx_ff, l_fmy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l_v_ff <= 1'b0;
      end else begin
         l_v_ff <= k_v_ff;
      end
      l_fmx_ff  <= l_sx[SUM_W-1:30];
      l_fmy_ff  <= l_sy[SUM_W-1:30];
      l_sfx_ff  <= k_sfx_ff;
      l_sfy_ff  <= k_sfy_ff;
      l_coin_ff <= k_coin_ff;
   end

   // stage m: saturation and result register
   localparam logic [FM_W-1:0] POS_MAX = FM_W'(32'h7fff_ffff);
   localparam logic [FM_W-1:0] NEG_MAX = FM_W'(33'h1_0000_0000) >> 1;

   logic [31:0] m_fx_in, m_fy_in;
   logic        m_satx, m_saty;

   always_comb begin
      m_satx = 1'b0;
      m_saty = 1'b0;
      if (l_sfx_ff) begin
         m_satx  = (l_fmx_ff > NEG_MAX);
         m_fx_in = m_satx ? 32'h8000_0000 : 32'(-l_fmx_ff[31:0]);
      end else begin
         m_satx  = (l_fmx_ff > POS_MAX);
         m_fx_in = m_satx ? 32'h7fff_ffff : l_fmx_ff[31:0];
      end
      if (l_sfy_ff) begin
         m_saty  = (l_fmy_ff > NEG_MAX);
         m_fy_in = m_saty ? 32'h8000_0000 : 32'(-l_fmy_ff[31:0]);
      end else begin
         m_saty  = (l_fmy_ff > POS_MAX);
         m_fy_in = m_saty ? 32'h7fff_ffff : l_fmy_ff[31:0];
      end
   end

   logic        m_v_ff, m_sat_ff, m_coin_ff;
   logic [31:0] m_fx_ff, m_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else begin
         m_v_ff <= l_v_ff;
      end
      m_fx_ff   <= l_coin_ff ? 32'd0 : m_fx_in;
      m_fy_ff   <= l_coin_ff ? 32'd0 : m_fy_in;
      m_sat_ff  <= l_coin_ff ? 1'b0 : (m_satx | m_saty);
      m_coin_ff <= l_coin_ff;
   end

   assign rsp_valid      = m_v_ff;
   assign rsp_force_x    = m_fx_ff;
   assign rsp_force_y    = m_fy_ff;
   assign rsp_saturated  = m_sat_ff;
   assign rsp_coincident = m_coin_ff;

endmodule
`default_nettype wire

// File: rtl/core/sdf_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module sdf_isqrt #(
   parameter int unsigned SIDE_W = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [sdf_pkg::RAD_W-1:0]  in_rad,
   input  wire logic [SIDE_W-1:0]          in_side,
   output logic                            out_valid,
   output logic [sdf_pkg::ROOT_W-1:0]      out_root,
   output logic [SIDE_W-1:0]               out_side
);

   localparam int unsigned N     = sdf_pkg::ROOT_W;
   localparam int unsigned RAD_W = sdf_pkg::RAD_W;
   localparam int unsigned REM_W = sdf_pkg::ROOT_W + 3;

   logic              valid_d [0:N];
   logic [RAD_W-1:0]  rad_d   [0:N];
   logic [REM_W-1:0]  rem_d   [0:N];
   logic [N-1:0]      root_d  [0:N];
   logic [SIDE_W-1:0] side_d  [0:N];

   assign valid_d[0] = in_valid;
   assign rad_d[0]   = in_rad;
   assign rem_d[0]   = '0;
   assign root_d[0]  = '0;
   assign side_d[0]  = in_side;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              valid_ff;
      logic [RAD_W-1:0]  rad_ff;
      logic [REM_W-1:0]  rem_ff;
      logic [N-1:0]      root_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;
      logic              fits;

      always_comb begin
         rem_cat = {rem_d[i][REM_W-3:0], rad_d[i][RAD_W-1 -: 2]};
         trial   = {1'b0, root_d[i], 2'b01};
         fits    = (rem_cat >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_d[i];
         end
         rad_ff  <= {rad_d[i][RAD_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_cat - trial : rem_cat;
         root_ff <= {root_d[i][N-2:0], fits};
         side_ff <= side_d[i];
      end

      assign valid_d[i+1] = valid_ff;
      assign rad_d[i+1]   = rad_ff;
      assign rem_d[i+1]   = rem_ff;
      assign root_d[i+1]  = root_ff;
      assign side_d[i+1]  = side_ff;
   end

   assign out_valid = valid_d[N];
   assign out_root  = root_d[N];
   assign out_side  = side_d[N];

endmodule
`default_nettype wire

// File: rtl/core/sdf_div.sv
// pipelined restoring divider for both unit vector components, one quotient bit per stage
`default_nettype none
module sdf_div #(
   parameter int unsigned SIDE_W = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [sdf_pkg::DIFF_W-1:0] in_num_x,
   input  wire logic [sdf_pkg::DIFF_W-1:0] in_num_y,
   input  wire logic [sdf_pkg::ROOT_W-1:0] in_den,
   input  wire logic [SIDE_W-1:0]          in_side,
   output logic                            out_valid,
   output logic [sdf_pkg::QUO_W-1:0]       out_quo_x,
   output logic [sdf_pkg::QUO_W-1:0]       out_quo_y,
   output logic [sdf_pkg::ROOT_W-1:0]      out_den,
   output logic [SIDE_W-1:0]               out_side
);

   localparam int unsigned N     = sdf_pkg::QUO_W;
   localparam int unsigned DEN_W = sdf_pkg::ROOT_W;
   localparam int unsigned REM_W = sdf_pkg::ROOT_W + 1;
   localparam int unsigned NUM_W = sdf_pkg::DIFF_W;

   logic              valid_d [0:N];
   logic [REM_W-1:0]  remx_d  [0:N];
   logic [REM_W-1:0]  remy_d  [0:N];
   logic [N-1:0]      bitx_d  [0:N];
   logic [N-1:0]      bity_d  [0:N];
   logic [N-1:0]      qx_d    [0:N];
   logic [N-1:0]      qy_d    [0:N];
   logic [DEN_W-1:0]  den_d   [0:N];
   logic [SIDE_W-1:0] side_d  [0:N];

   assign valid_d[0] = in_valid;
   assign remx_d[0]  = REM_W'(in_num_x[NUM_W-1:1]);
   assign remy_d[0]  = REM_W'(in_num_y[NUM_W-1:1]);
   assign bitx_d[0]  = {in_num_x[0], {(N-1){1'b0}}};
   assign bity_d[0]  = {in_num_y[0], {(N-1){1'b0}}};
   assign qx_d[0]    = '0;
   assign qy_d[0]    = '0;
   assign den_d[0]   = in_den;
   assign side_d[0]  = in_side;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              valid_ff;
      logic [REM_W-1:0]  remx_ff;
      logic [REM_W-1:0]  remy_ff;
      logic [N-1:0]      bitx_ff;
      logic [N-1:0]      bity_ff;
      logic [N-1:0]      qx_ff;
      logic [N-1:0]      qy_ff;
      logic [DEN_W-1:0]  den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [REM_W-1:0]  catx;
      logic [REM_W-1:0]  caty;
      logic              gex;
      logic              gey;

      always_comb begin
         catx = {remx_d[i][REM_W-2:0], bitx_d[i][N-1]};
         caty = {remy_d[i][REM_W-2:0], bity_d[i][N-1]};
         gex  = (catx >= {1'b0, den_d[i]});
         gey  = (caty >= {1'b0, den_d[i]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_d[i];
         end
         remx_ff <= gex ? catx - {1'b0, den_d[i]} : catx;
         remy_ff <= gey ? caty - {1'b0, den_d[i]} : caty;
         bitx_ff <= {bitx_d[i][N-2:0], 1'b0};
         bity_ff <= {bity_d[i][N-2:0], 1'b0};
         qx_ff   <= {qx_d[i][N-2:0], gex};
         qy_ff   <= {qy_d[i][N-2:0], gey};
         den_ff  <= den_d[i];
         side_ff <= side_d[i];
      end

      assign valid_d[i+1] = valid_ff;
      assign remx_d[i+1]  = remx_ff;
      assign remy_d[i+1]  = remy_ff;
      assign bitx_d[i+1]  = bitx_ff;
      assign bity_d[i+1]  = bity_ff;
      assign qx_d[i+1]    = qx_ff;
      assign qy_d[i+1]    = qy_ff;
      assign den_d[i+1]   = den_ff;
      assign side_d[i+1]  = side_ff;
   end

   assign out_valid = valid_d[N];
   assign out_quo_x = qx_d[N];
   assign out_quo_y = qy_d[N];
   assign out_den   = den_d[N];
   assign out_side  = side_d[N];

endmodule
`default_nettype wire
